### src/ast_pkg.sv
package ast_pkg;

  localparam int SLOTS_DEF    = 64;
  localparam int TAG_BITS_DEF = 16;

  localparam int OPCODE_W = 2;
  localparam int SLOT_W   = 6;
  localparam int TAG_W    = 16;
  localparam int CODE_W   = 3;

  typedef enum logic [OPCODE_W-1:0] {
    OP_CLAIM    = 2'd0,
    OP_COMPLETE = 2'd1,
    OP_DRAIN    = 2'd2
  } op_t;

  localparam logic [CODE_W-1:0] RC_OK         = 3'd0;
  localparam logic [CODE_W-1:0] RC_FULL       = 3'd1;
  localparam logic [CODE_W-1:0] RC_NOT_AWAIT  = 3'd2;
  localparam logic [CODE_W-1:0] RC_ALREADY    = 3'd3;
  localparam logic [CODE_W-1:0] RC_EMPTY      = 3'd4;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

endpackage

### src/await_slot_tracker_top.sv
// Await slot tracker: SLOTS slots linked through one next-pointer table that
// holds a free list and a LIFO completion list. Each request is taken in the
// idle state and its table entry is read at that edge; the update and the
// result follow in the execute state once the output register is free. A drain
// gives one result per cycle while the output is not stalled, newest
// completion first, because each step needs the link read from the slot
// before it. Unused opcode 3 is taken in the idle state with no result. The
// input stalls while a request is in progress, and a request stays in progress
// while its result cannot be placed into the output register.
module await_slot_tracker_top #(
  parameter int SLOTS    = ast_pkg::SLOTS_DEF,
  parameter int TAG_BITS = ast_pkg::TAG_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ast_pkg::OPCODE_W-1:0]  in_opcode,
  input  logic [ast_pkg::SLOT_W-1:0]    in_slot,
  input  logic [ast_pkg::TAG_W-1:0]     in_task_tag,
  input  logic                          in_fail_flag,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ast_pkg::CODE_W-1:0]    out_result_code,
  output logic [ast_pkg::SLOT_W-1:0]    out_slot_index,
  output logic [ast_pkg::TAG_W-1:0]     out_tag_out,
  output logic                          out_failed_out,
  output logic                          out_last_result
);

  localparam int AW = $clog2(SLOTS);
  localparam int LW = $clog2(SLOTS + 1);
  localparam int DW = LW + 3 + TAG_BITS;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [DW-1:0] mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [DW-1:0] mem_rdata;

  ast_ctrl #(
    .SLOTS    (SLOTS),
    .TAG_BITS (TAG_BITS),
    .AW       (AW),
    .LW       (LW),
    .DW       (DW)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_slot         (in_slot),
    .in_task_tag     (in_task_tag),
    .in_fail_flag    (in_fail_flag),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_code (out_result_code),
    .out_slot_index  (out_slot_index),
    .out_tag_out     (out_tag_out),
    .out_failed_out  (out_failed_out),
    .out_last_result (out_last_result),
    .mem_we          (mem_we),
    .mem_waddr       (mem_waddr),
    .mem_wdata       (mem_wdata),
    .mem_re          (mem_re),
    .mem_raddr       (mem_raddr),
    .mem_rdata       (mem_rdata)
  );

  ast_slot_mem #(
    .DEPTH (SLOTS),
    .AW    (AW),
    .LW    (LW),
    .DW    (DW)
  ) u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

### src/ast_slot_mem.sv
module ast_slot_mem #(
  parameter int DEPTH = ast_pkg::SLOTS_DEF,
  parameter int AW    = $clog2(DEPTH),
  parameter int LW    = $clog2(DEPTH + 1),
  parameter int DW    = LW + 3 + ast_pkg::TAG_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [DW-1:0]    raw_r;
  logic             rd_vld_r;
  logic [AW-1:0]    rd_addr_r;
  logic [LW-1:0]    rst_link;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      raw_r     <= mem[raddr];
      rd_addr_r <= raddr;
    end
  end

  // valid bits stand in for the reset image: entry i links to i+1, flags clear
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      if (re) begin
        rd_vld_r <= vld_r[raddr];
      end
    end
  end

  assign rst_link = LW'(rd_addr_r) + LW'(1);
  assign rdata    = rd_vld_r ? raw_r : {rst_link, {(DW - LW){1'b0}}};

endmodule

### src/ast_ctrl.sv
module ast_ctrl #(
  parameter int SLOTS    = ast_pkg::SLOTS_DEF,
  parameter int TAG_BITS = ast_pkg::TAG_BITS_DEF,
  parameter int AW       = $clog2(SLOTS),
  parameter int LW       = $clog2(SLOTS + 1),
  parameter int DW       = LW + 3 + TAG_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ast_pkg::OPCODE_W-1:0]  in_opcode,
  input  logic [ast_pkg::SLOT_W-1:0]    in_slot,
  input  logic [ast_pkg::TAG_W-1:0]     in_task_tag,
  input  logic                          in_fail_flag,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ast_pkg::CODE_W-1:0]    out_result_code,
  output logic [ast_pkg::SLOT_W-1:0]    out_slot_index,
  output logic [ast_pkg::TAG_W-1:0]     out_tag_out,
  output logic                          out_failed_out,
  output logic                          out_last_result,
  output logic                          mem_we,
  output logic [AW-1:0]                 mem_waddr,
  output logic [DW-1:0]                 mem_wdata,
  output logic                          mem_re,
  output logic [AW-1:0]                 mem_raddr,
  input  logic [DW-1:0]                 mem_rdata
);

  localparam logic [LW-1:0] NIL     = LW'(SLOTS);
  localparam int            AWT_BIT = TAG_BITS + 2;
  localparam int            DON_BIT = TAG_BITS + 1;
  localparam int            FLD_BIT = TAG_BITS;

  ast_pkg::state_t state_r, state_nxt;
  ast_pkg::op_t    op_r, op_nxt;
  logic [ast_pkg::SLOT_W-1:0] slot_r, slot_nxt;
  logic [TAG_BITS-1:0]        tag_r, tag_nxt;
  logic                       fail_r, fail_nxt;
  logic [LW-1:0]              free_head_r, free_head_nxt;
  logic [LW-1:0]              done_head_r, done_head_nxt;
  logic [LW-1:0]              cnt_r, cnt_nxt;
  logic [AW-1:0]              cur_r, cur_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic [ast_pkg::CODE_W-1:0] code_r, code_nxt;
  logic [ast_pkg::SLOT_W-1:0] oslot_r, oslot_nxt;
  logic [ast_pkg::TAG_W-1:0]  otag_r, otag_nxt;
  logic                       ofail_r, ofail_nxt;
  logic                       olast_r, olast_nxt;

  logic [LW-1:0]       rd_link;
  logic                rd_await;
  logic                rd_done;
  logic                rd_failed;
  logic [TAG_BITS-1:0] rd_tag;
  logic                out_free;
  logic                last_w;
  logic [LW-1:0]       cnt_inc;

  assign rd_link   = mem_rdata[DW-1 -: LW];
  assign rd_await  = mem_rdata[AWT_BIT];
  assign rd_done   = mem_rdata[DON_BIT];
  assign rd_failed = mem_rdata[FLD_BIT];
  assign rd_tag    = mem_rdata[TAG_BITS-1:0];

  assign out_free = !out_valid_r || !out_stall;
  assign cnt_inc  = cnt_r + LW'(1);
  assign last_w   = (rd_link >= NIL) || (cnt_inc >= NIL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ast_pkg::ST_IDLE;
      free_head_r <= '0;
      done_head_r <= NIL;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      free_head_r <= free_head_nxt;
      done_head_r <= done_head_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    slot_r  <= slot_nxt;
    tag_r   <= tag_nxt;
    fail_r  <= fail_nxt;
    cnt_r   <= cnt_nxt;
    cur_r   <= cur_nxt;
    code_r  <= code_nxt;
    oslot_r <= oslot_nxt;
    otag_r  <= otag_nxt;
    ofail_r <= ofail_nxt;
    olast_r <= olast_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    slot_nxt      = slot_r;
    tag_nxt       = tag_r;
    fail_nxt      = fail_r;
    free_head_nxt = free_head_r;
    done_head_nxt = done_head_r;
    cnt_nxt       = cnt_r;
    cur_nxt       = cur_r;
    out_valid_nxt = out_valid_r && out_stall;
    code_nxt      = code_r;
    oslot_nxt     = oslot_r;
    otag_nxt      = otag_r;
    ofail_nxt     = ofail_r;
    olast_nxt     = olast_r;
    in_stall      = 1'b1;
    mem_we        = 1'b0;
    mem_waddr     = cur_r;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = cur_r;

    unique case (state_r)
      ast_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          op_nxt   = ast_pkg::op_t'(in_opcode);
          slot_nxt = in_slot;
          tag_nxt  = TAG_BITS'(in_task_tag);
          fail_nxt = in_fail_flag;
          cnt_nxt  = '0;
          case (ast_pkg::op_t'(in_opcode))
            ast_pkg::OP_CLAIM: begin
              mem_re    = 1'b1;
              mem_raddr = free_head_r[AW-1:0];
              state_nxt = ast_pkg::ST_EXEC;
            end
            ast_pkg::OP_COMPLETE: begin
              mem_re    = 1'b1;
              mem_raddr = in_slot[AW-1:0];
              state_nxt = ast_pkg::ST_EXEC;
            end
            ast_pkg::OP_DRAIN: begin
              mem_re    = 1'b1;
              mem_raddr = done_head_r[AW-1:0];
              state_nxt = ast_pkg::ST_EXEC;
            end
            default: ;  // unused opcode: dropped
          endcase
          cur_nxt = mem_raddr;
        end
      end

      ast_pkg::ST_EXEC: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          code_nxt      = ast_pkg::RC_OK;
          oslot_nxt     = '0;
          otag_nxt      = '0;
          ofail_nxt     = 1'b0;
          olast_nxt     = 1'b1;
          state_nxt     = ast_pkg::ST_IDLE;
          case (op_r)
            ast_pkg::OP_CLAIM: begin
              if (free_head_r >= NIL) begin
                code_nxt = ast_pkg::RC_FULL;
              end else begin
                free_head_nxt = rd_link;
                mem_we        = 1'b1;
                mem_wdata     = {NIL, 1'b1, 1'b0, 1'b0, tag_r};
                oslot_nxt     = ast_pkg::SLOT_W'(cur_r);
              end
            end
            ast_pkg::OP_COMPLETE: begin
              oslot_nxt = slot_r;
              if (({1'b0, slot_r} >= (ast_pkg::SLOT_W + 1)'(SLOTS)) || !rd_await) begin
                code_nxt = ast_pkg::RC_NOT_AWAIT;
              end else if (rd_done) begin
                code_nxt = ast_pkg::RC_ALREADY;
              end else begin
                mem_we        = 1'b1;
                mem_wdata     = {done_head_r, 1'b1, 1'b1, rd_failed | fail_r, rd_tag};
                done_head_nxt = LW'(cur_r);
              end
            end
            ast_pkg::OP_DRAIN: begin
              if (done_head_r >= NIL) begin
                code_nxt = ast_pkg::RC_EMPTY;
              end else begin
                // put cur on the free list, fetch the next completed slot
                oslot_nxt     = ast_pkg::SLOT_W'(cur_r);
                otag_nxt      = ast_pkg::TAG_W'(rd_tag);
                ofail_nxt     = rd_failed | fail_r;
                olast_nxt     = last_w;
                mem_we        = 1'b1;
                mem_wdata     = {free_head_r, 1'b0, 1'b0, 1'b0, rd_tag};
                free_head_nxt = LW'(cur_r);
                done_head_nxt = (rd_link >= NIL) ? NIL : rd_link;
                cnt_nxt       = cnt_inc;
                if (!last_w) begin
                  mem_re    = 1'b1;
                  mem_raddr = rd_link[AW-1:0];
                  cur_nxt   = rd_link[AW-1:0];
                  state_nxt = ast_pkg::ST_EXEC;
                end
              end
            end
            default: begin
              out_valid_nxt = out_valid_r && out_stall;
            end
          endcase
        end
      end

      default: state_nxt = ast_pkg::ST_IDLE;
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_result_code = code_r;
  assign out_slot_index  = oslot_r;
  assign out_tag_out     = otag_r;
  assign out_failed_out  = ofail_r;
  assign out_last_result = olast_r;

endmodule

### test/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ast_pkg::*;

  localparam int SLOTS = SLOTS_DEF;
  localparam logic [6:0] LINK_NIL = 7'd64;
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam int MAX_SHOWN = 10;

  typedef struct {
    logic [OPCODE_W-1:0] opcode;
    logic [SLOT_W-1:0]   slot;
    logic [TAG_W-1:0]    tag;
    logic                fail;
  } request_t;

  typedef struct {
    logic [CODE_W-1:0] code;
    logic [SLOT_W-1:0] slot;
    logic [TAG_W-1:0]  tag;
    logic              failed;
    logic              last;
  } slot_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [OPCODE_W-1:0] in_opcode = '0;
  logic [SLOT_W-1:0]   in_slot = '0;
  logic [TAG_W-1:0]    in_task_tag = '0;
  logic                in_fail_flag = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [CODE_W-1:0]   out_result_code;
  logic [SLOT_W-1:0]   out_slot_index;
  logic [TAG_W-1:0]    out_tag_out;
  logic                out_failed_out;
  logic                out_last_result;

  request_t     pending_reqs[$];
  request_t     drv_req;
  slot_result_t due_results[$];
  int           mismatches = 0;
  int           src_idle_pct = 0;
  int           snk_stall_pct = 0;

  // Shadow of the slot table: one link array shared by free and completion lists
  logic [6:0]       link_next [SLOTS];
  logic [6:0]       free_head;
  logic [6:0]       done_head;
  logic             awaiting [SLOTS];
  logic             notified [SLOTS];
  logic             failed   [SLOTS];
  logic [TAG_W-1:0] tag_of   [SLOTS];

  await_slot_tracker_top i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_slot         (in_slot),
    .in_task_tag     (in_task_tag),
    .in_fail_flag    (in_fail_flag),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_code (out_result_code),
    .out_slot_index  (out_slot_index),
    .out_tag_out     (out_tag_out),
    .out_failed_out  (out_failed_out),
    .out_last_result (out_last_result)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  function automatic void push_result(logic [CODE_W-1:0] code, logic [SLOT_W-1:0] slot,
                                      logic [TAG_W-1:0] tag, logic fl, logic last);
    slot_result_t r;
    r.code   = code;
    r.slot   = slot;
    r.tag    = tag;
    r.failed = fl;
    r.last   = last;
    due_results.push_back(r);
  endfunction

  function automatic void apply_to_table(request_t r);
    int                cur;
    int                n;
    logic [6:0]        nxt;
    logic [SLOT_W-1:0] s;
    if (r.opcode == OP_CLAIM) begin
      if (free_head >= LINK_NIL) begin
        push_result(RC_FULL, '0, '0, 1'b0, 1'b1);
      end else begin
        s = free_head[SLOT_W-1:0];
        free_head = link_next[s];
        tag_of[s] = r.tag;
        link_next[s] = LINK_NIL;
        awaiting[s] = 1'b1;
        notified[s] = 1'b0;
        failed[s] = 1'b0;
        push_result(RC_OK, s, '0, 1'b0, 1'b1);
      end
    end else if (r.opcode == OP_COMPLETE) begin
      if (!awaiting[r.slot]) begin
        push_result(RC_NOT_AWAIT, r.slot, '0, 1'b0, 1'b1);
      end else if (notified[r.slot]) begin
        push_result(RC_ALREADY, r.slot, '0, 1'b0, 1'b1);
      end else begin
        link_next[r.slot] = done_head;
        done_head = {1'b0, r.slot};
        notified[r.slot] = 1'b1;
        if (r.fail) failed[r.slot] = 1'b1;
        push_result(RC_OK, r.slot, '0, 1'b0, 1'b1);
      end
    end else if (r.opcode == OP_DRAIN) begin
      if (done_head >= LINK_NIL) begin
        push_result(RC_EMPTY, '0, '0, 1'b0, 1'b1);
      end else begin
        cur = int'(done_head);
        n = 0;
        // newest completion first; each drained slot goes back on the free list
        while (cur < SLOTS && n < SLOTS) begin
          nxt = link_next[cur];
          push_result(RC_OK, SLOT_W'(cur), tag_of[cur], failed[cur] | r.fail,
                      (nxt >= LINK_NIL) || (n + 1 >= SLOTS));
          n++;
          awaiting[cur] = 1'b0;
          notified[cur] = 1'b0;
          failed[cur] = 1'b0;
          link_next[cur] = free_head;
          free_head = 7'(cur);
          done_head = (nxt >= LINK_NIL) ? LINK_NIL : nxt;
          cur = int'(nxt);
        end
      end
    end
  endfunction

  // Request driver: the shadow table is updated at the edge that takes a request
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) apply_to_table(drv_req);
      if (!in_valid || !in_stall) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          drv_req = pending_reqs.pop_front();
          in_valid     <= 1'b1;
          in_opcode    <= drv_req.opcode;
          in_slot      <= drv_req.slot;
          in_task_tag  <= drv_req.tag;
          in_fail_flag <= drv_req.fail;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    slot_result_t e;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("unexpected result: code %0d slot %0d tag %h failed %0b last %0b",
                     out_result_code, out_slot_index, out_tag_out, out_failed_out,
                     out_last_result);
        end else begin
          e = due_results.pop_front();
          if (out_result_code !== e.code || out_slot_index !== e.slot ||
              out_tag_out !== e.tag || out_failed_out !== e.failed ||
              out_last_result !== e.last) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
              $display("mismatch exp/got: code %0d/%0d slot %0d/%0d tag %h/%h %s",
                       e.code, out_result_code, e.slot, out_slot_index, e.tag, out_tag_out,
                       $sformatf("failed %0b/%0b last %0b/%0b", e.failed, out_failed_out,
                                 e.last, out_last_result));
          end
        end
      end
      out_stall <= ($urandom_range(99) < snk_stall_pct);
    end
  end

  task automatic send(logic [OPCODE_W-1:0] op, logic [SLOT_W-1:0] slot,
                      logic [TAG_W-1:0] tag, logic fl);
    request_t r;
    while (pending_reqs.size() != 0) @(negedge clk);
    r.opcode = op;
    r.slot   = slot;
    r.tag    = tag;
    r.fail   = fl;
    pending_reqs.push_back(r);
  endtask

  task automatic wait_quiet();
    while (pending_reqs.size() != 0 || in_valid || due_results.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  initial begin : stimulus
    int                i;
    int                ph;
    int                k;
    int                roll;
    int                idx;
    int                open_slots[$];
    int                closed_slots[$];
    logic [SLOT_W-1:0] pick;

    for (i = 0; i < SLOTS; i++) begin
      link_next[i] = 7'(i + 1);
      awaiting[i] = 1'b0;
      notified[i] = 1'b0;
      failed[i] = 1'b0;
      tag_of[i] = '0;
    end
    link_next[SLOTS-1] = LINK_NIL;
    free_head = '0;
    done_head = LINK_NIL;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send(OP_DRAIN,    6'd0,  16'h0000, 1'b0);  // nothing completed yet
    send(OP_COMPLETE, 6'd0,  16'h0000, 1'b0);  // slot never claimed
    send(OP_COMPLETE, 6'd63, 16'hFFFF, 1'b1);
    send(OP_CLAIM,    6'd63, 16'h0000, 1'b1);
    send(OP_CLAIM,    6'd0,  16'hFFFF, 1'b0);
    send(OP_CLAIM,    6'd21, 16'hA5A5, 1'b0);
    send(OP_UNUSED,   6'd42, 16'h5A5A, 1'b1);  // dropped, no result
    send(OP_COMPLETE, 6'd1,  16'h0000, 1'b1);
    send(OP_COMPLETE, 6'd1,  16'hFFFF, 1'b0);  // second completion ignored
    send(OP_COMPLETE, 6'd0,  16'h0000, 1'b0);
    send(OP_COMPLETE, 6'd2,  16'h0000, 1'b0);
    send(OP_DRAIN,    6'd0,  16'h0000, 1'b0);  // three results, LIFO
    send(OP_DRAIN,    6'd0,  16'h0000, 1'b1);
    send(OP_CLAIM,    6'd0,  16'h1234, 1'b0);  // reuses the last freed slot
    send(OP_COMPLETE, 6'd1,  16'h0000, 1'b0);
    send(OP_DRAIN,    6'd0,  16'h0000, 1'b1);  // forced failure
    send(OP_COMPLETE, 6'd1,  16'h0000, 1'b0);
    send(OP_COMPLETE, 6'd2,  16'h0000, 1'b1);
    wait_quiet();

    for (ph = 0; ph < 4; ph++) begin
      src_idle_pct  = (ph == 1) ? 52 : (ph == 3) ? 26 : 0;
      snk_stall_pct = (ph == 2) ? 52 : (ph == 3) ? 26 : 0;
      for (k = 0; k < 30; k++) begin
        while (pending_reqs.size() != 0) @(negedge clk);
        open_slots.delete();
        closed_slots.delete();
        for (i = 0; i < SLOTS; i++) begin
          if (awaiting[i] && !notified[i]) open_slots.push_back(i);
          else if (notified[i]) closed_slots.push_back(i);
        end
        pick = SLOT_W'($urandom_range(SLOTS - 1));
        roll = $urandom_range(99);
        if (roll < 4) begin
          send(OP_UNUSED, pick, TAG_W'($urandom), 1'($urandom));
        end else if (roll < 40) begin
          send(OP_CLAIM, pick, TAG_W'($urandom), 1'($urandom));
        end else if (roll < 85) begin
          roll = $urandom_range(99);
          if (roll < 80 && open_slots.size() != 0)
            pick = SLOT_W'(open_slots[$urandom_range(open_slots.size() - 1)]);
          else if (roll < 90 && closed_slots.size() != 0)
            pick = SLOT_W'(closed_slots[$urandom_range(closed_slots.size() - 1)]);
          send(OP_COMPLETE, pick, TAG_W'($urandom), $urandom_range(99) < 30);
        end else begin
          send(OP_DRAIN, pick, TAG_W'($urandom), $urandom_range(99) < 25);
        end
      end

      if (ph == 2) begin
        // run the table full, complete every slot in random order, drain it in one go
        for (i = 0; i < SLOTS + 4; i++)
          send(OP_CLAIM, SLOT_W'($urandom), TAG_W'($urandom), 1'($urandom));
        while (pending_reqs.size() != 0 || in_valid) @(negedge clk);
        open_slots.delete();
        for (i = 0; i < SLOTS; i++)
          if (awaiting[i] && !notified[i]) open_slots.push_back(i);
        while (open_slots.size() != 0) begin
          idx = $urandom_range(open_slots.size() - 1);
          send(OP_COMPLETE, SLOT_W'(open_slots[idx]), TAG_W'($urandom),
               $urandom_range(99) < 40);
          open_slots.delete(idx);
        end
        send(OP_DRAIN, SLOT_W'($urandom), TAG_W'($urandom), 1'($urandom));
        send(OP_DRAIN, SLOT_W'($urandom), TAG_W'($urandom), 1'($urandom));
      end

      // sender holds off until every result of this phase is back
      wait_quiet();
    end

    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
